>>> rtl/core/stt_pkg.sv
package stt_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_source;
    } t_tok_in;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [15:0] start_pos;
        logic [7:0]  token_len;
        logic [15:0] line_no;
        logic [2:0]  error_code;
        logic        is_last;
    } t_tok_out;

    // All tokens one source character can release, in order.
    typedef struct packed {
        logic [1:0]         cnt;
        t_tok_out [2:0]     res;
    } t_rec;

    localparam logic [5:0] K_EOF     = 6'd0;
    localparam logic [5:0] K_IDENT   = 6'd1;
    localparam logic [5:0] K_NUMBER  = 6'd2;
    localparam logic [5:0] K_STRING  = 6'd3;
    localparam logic [5:0] K_COMMENT = 6'd4;
    localparam logic [5:0] K_KEYWORD0 = 6'd5;
    localparam logic [5:0] K_LPAREN  = 6'd12;
    localparam logic [5:0] K_RPAREN  = 6'd13;
    localparam logic [5:0] K_LBRACE  = 6'd14;
    localparam logic [5:0] K_RBRACE  = 6'd15;
    localparam logic [5:0] K_COMMA   = 6'd16;
    localparam logic [5:0] K_SEMI    = 6'd17;
    localparam logic [5:0] K_DOT     = 6'd18;
    localparam logic [5:0] K_COLON   = 6'd19;
    localparam logic [5:0] K_MINUS   = 6'd20;
    localparam logic [5:0] K_PERCENT = 6'd21;
    localparam logic [5:0] K_PLUS    = 6'd22;
    localparam logic [5:0] K_SLASH   = 6'd23;
    localparam logic [5:0] K_STAR    = 6'd24;
    localparam logic [5:0] K_GT      = 6'd25;
    localparam logic [5:0] K_GE      = 6'd26;
    localparam logic [5:0] K_LT      = 6'd27;
    localparam logic [5:0] K_LE      = 6'd28;
    localparam logic [5:0] K_ASSIGN  = 6'd29;
    localparam logic [5:0] K_EQ      = 6'd30;
    localparam logic [5:0] K_ANDAND  = 6'd31;
    localparam logic [5:0] K_OROR    = 6'd32;
    localparam logic [5:0] K_NOT     = 6'd33;
    localparam logic [5:0] K_NE      = 6'd34;
    localparam logic [5:0] K_ERROR   = 6'd35;
    localparam logic [5:0] K_NONE    = 6'd0;

    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_UNTERM   = 3'd1;
    localparam logic [2:0] E_UNKNOWN  = 3'd2;
    localparam logic [2:0] E_LONE     = 3'd3;
    localparam logic [2:0] E_TRAILING = 3'd4;

    localparam int QUEUE_DEPTH = 4;

endpackage

>>> rtl/core/stt_front.sv
module stt_front import stt_pkg::*; #(
    parameter int POSITION_BITS = 16,
    parameter int LENGTH_BITS   = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_tok_in i_word,
    input  logic    i_q_full,
    output logic    o_push,
    output t_rec    o_rec
);

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_NUMDOT, M_FRACTION,
        M_STRING, M_COMMENT, M_PENDING, M_STOPPED
    } t_mode;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [LENGTH_BITS-1:0]   LEN_MAX = '1;

    t_mode                    r_mode, n_mode;
    logic [6:0]               r_kc, n_kc;
    logic [7:0]               r_ps, n_ps;
    logic [POSITION_BITS-1:0] r_ts, n_ts, r_tln, n_tln, r_cp, n_cp, r_cl, n_cl;
    logic [LENGTH_BITS-1:0]   r_tl, n_tl;

    t_tok_out [2:0] res;
    logic [1:0]     cnt;
    logic           restart;
    logic           accept;
    logic [7:0]     c;
    logic [5:0]     k;
    logic [POSITION_BITS:0] dp;

    function automatic logic [2:0] kw_len(input int kk);
        case (kk)
            0: return 3'd2;
            1: return 3'd4;
            2: return 3'd3;
            3: return 3'd6;
            4: return 3'd2;
            5: return 3'd7;
            default: return 3'd6;
        endcase
    endfunction

    function automatic logic [7:0] kw_char(input int kk, input logic [2:0] idx);
        logic [55:0] w;
        logic [2:0]  sh;
        case (kk)
            0: w = 56'("if");
            1: w = 56'("else");
            2: w = 56'("for");
            3: w = 56'("return");
            4: w = 56'("fn");
            5: w = 56'("println");
            default: w = 56'("readIn");
        endcase
        sh = (idx < kw_len(kk)) ? kw_len(kk) - 3'd1 - idx : 3'd0;
        return w[sh*8 +: 8];
    endfunction

    function automatic logic [6:0] narrow(input logic [6:0] kc,
                                          input logic [LENGTH_BITS-1:0] idx,
                                          input logic [7:0] ch);
        logic [6:0] o;
        o = kc;
        for (int kk = 0; kk < 7; kk++) begin
            if (idx >= LENGTH_BITS'(kw_len(kk)) || kw_char(kk, idx[2:0]) != ch) begin
                o[kk] = 1'b0;
            end
        end
        return o;
    endfunction

    function automatic logic [5:0] ident_kind(input logic [6:0] kc,
                                              input logic [LENGTH_BITS-1:0] len);
        logic [5:0] o;
        o = K_IDENT;
        for (int kk = 6; kk >= 0; kk--) begin
            if (kc[kk] && len == LENGTH_BITS'(kw_len(kk))) begin
                o = K_KEYWORD0 + 6'(kk);
            end
        end
        return o;
    endfunction

    function automatic logic [5:0] punct_kind(input logic [7:0] ch);
        case (ch)
            "(": return K_LPAREN;
            ")": return K_RPAREN;
            "{": return K_LBRACE;
            "}": return K_RBRACE;
            ",": return K_COMMA;
            ";": return K_SEMI;
            ".": return K_DOT;
            ":": return K_COLON;
            default: return K_NONE;
        endcase
    endfunction

    function automatic logic [5:0] op_kind(input logic [7:0] ch);
        case (ch)
            "-": return K_MINUS;
            "%": return K_PERCENT;
            "+": return K_PLUS;
            "/": return K_SLASH;
            "*": return K_STAR;
            ">": return K_GT;
            "<": return K_LT;
            "=": return K_ASSIGN;
            "!": return K_NOT;
            default: return K_NONE;
        endcase
    endfunction

    function automatic logic [5:0] pair_kind(input logic [7:0] p, input logic [7:0] ch);
        logic [5:0] o;
        o = K_NONE;
        if (ch == "=") begin
            case (p)
                ">": o = K_GE;
                "<": o = K_LE;
                "=": o = K_EQ;
                "!": o = K_NE;
                default: o = K_NONE;
            endcase
        end
        if (p == "&" && ch == "&") o = K_ANDAND;
        if (p == "|" && ch == "|") o = K_OROR;
        return o;
    endfunction

    function automatic t_tok_out mk(input logic [5:0] kind,
                                    input logic [POSITION_BITS-1:0] st,
                                    input logic [LENGTH_BITS-1:0] len,
                                    input logic [POSITION_BITS-1:0] ln,
                                    input logic [2:0] err, input logic last);
        t_tok_out t;
        t.token_kind = kind;
        t.start_pos  = 16'(st);
        t.token_len  = 8'(len);
        t.line_no    = 16'(ln);
        t.error_code = err;
        t.is_last    = last;
        return t;
    endfunction

    function automatic void push(inout t_tok_out [2:0] r, inout logic [1:0] n,
                                 input t_tok_out t);
        if (n != 2'd3) begin
            r[n] = t;
            n = n + 2'd1;
        end
    endfunction

    function automatic logic [LENGTH_BITS-1:0] len_inc(input logic [LENGTH_BITS-1:0] v);
        return (v == LEN_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [POSITION_BITS-1:0] pos_inc(
            input logic [POSITION_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic is_alpha(input logic [7:0] ch);
        return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return ch >= "0" && ch <= "9";
    endfunction

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign c       = i_word.ch;

    always_comb begin
        n_mode = r_mode; n_kc = r_kc; n_ps = r_ps; n_ts = r_ts; n_tl = r_tl;
        n_tln = r_tln; n_cp = r_cp; n_cl = r_cl;
        res = '0; cnt = 2'd0; restart = 1'b0; k = K_NONE;
        dp = (POSITION_BITS+1)'(r_ts) + (POSITION_BITS+1)'(r_tl);
        if (r_mode == M_STOPPED) begin
            // hold: nothing more until reset
        end else if (i_word.end_of_source) begin
            n_mode = M_STOPPED;
            unique case (r_mode)
                M_IDENT: push(res, cnt, mk(ident_kind(r_kc, r_tl), r_ts, r_tl, r_tln,
                                           E_NONE, 1'b0));
                M_NUMBER, M_FRACTION:
                    push(res, cnt, mk(K_NUMBER, r_ts, r_tl, r_tln, E_NONE, 1'b0));
                M_NUMDOT: begin
                    push(res, cnt, mk(K_NUMBER, r_ts, r_tl, r_tln, E_NONE, 1'b0));
                    push(res, cnt, mk(K_DOT, dp[POSITION_BITS] ? POS_MAX
                                      : dp[POSITION_BITS-1:0], LENGTH_BITS'(1), r_tln,
                                      E_NONE, 1'b0));
                end
                M_COMMENT: push(res, cnt, mk(K_COMMENT, r_ts, r_tl, r_tln, E_NONE, 1'b0));
                M_STRING: push(res, cnt, mk(K_ERROR, r_ts, r_tl, r_tln, E_UNTERM, 1'b1));
                M_PENDING: push(res, cnt, mk(K_ERROR, r_ts, r_tl, r_tln, E_TRAILING,
                                             1'b1));
                default: ;
            endcase
            if (r_mode != M_STRING && r_mode != M_PENDING) begin
                push(res, cnt, mk(K_EOF, r_cp, '0, r_cl, E_NONE, 1'b1));
            end
        end else begin
            unique case (r_mode)
                M_STRING: begin
                    n_tl = len_inc(r_tl);
                    if (c == "\"") begin
                        push(res, cnt, mk(K_STRING, r_ts, n_tl, r_tln, E_NONE, 1'b0));
                        n_mode = M_IDLE;
                    end
                end
                M_COMMENT: begin
                    n_tl = len_inc(r_tl);
                    if (c == "#") begin
                        push(res, cnt, mk(K_COMMENT, r_ts, n_tl, r_tln, E_NONE, 1'b0));
                        n_mode = M_IDLE;
                    end
                end
                M_IDENT: begin
                    if (is_alpha(c)) begin
                        n_kc = narrow(r_kc, r_tl, c);
                        n_tl = len_inc(r_tl);
                    end else begin
                        push(res, cnt, mk(ident_kind(r_kc, r_tl), r_ts, r_tl, r_tln,
                                          E_NONE, 1'b0));
                        restart = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (is_digit(c)) n_tl = len_inc(r_tl);
                    else if (c == ".") n_mode = M_NUMDOT;
                    else begin
                        push(res, cnt, mk(K_NUMBER, r_ts, r_tl, r_tln, E_NONE, 1'b0));
                        restart = 1'b1;
                    end
                end
                M_NUMDOT: begin
                    if (is_digit(c)) begin
                        n_tl = len_inc(len_inc(r_tl));
                        n_mode = M_FRACTION;
                    end else begin
                        // number ends before the dot, dot stands alone
                        push(res, cnt, mk(K_NUMBER, r_ts, r_tl, r_tln, E_NONE, 1'b0));
                        push(res, cnt, mk(K_DOT, dp[POSITION_BITS] ? POS_MAX
                                          : dp[POSITION_BITS-1:0], LENGTH_BITS'(1),
                                          r_tln, E_NONE, 1'b0));
                        restart = 1'b1;
                    end
                end
                M_FRACTION: begin
                    if (is_digit(c)) n_tl = len_inc(r_tl);
                    else begin
                        push(res, cnt, mk(K_NUMBER, r_ts, r_tl, r_tln, E_NONE, 1'b0));
                        restart = 1'b1;
                    end
                end
                M_PENDING: begin
                    if (pair_kind(r_ps, c) != K_NONE) begin
                        n_tl = LENGTH_BITS'(2);
                        push(res, cnt, mk(pair_kind(r_ps, c), r_ts, n_tl, r_tln,
                                          E_NONE, 1'b0));
                        n_mode = M_IDLE;
                    end else if (op_kind(r_ps) == K_NONE) begin
                        push(res, cnt, mk(K_ERROR, r_ts, r_tl, r_tln, E_LONE, 1'b1));
                        n_mode = M_STOPPED;
                    end else begin
                        push(res, cnt, mk(op_kind(r_ps), r_ts, r_tl, r_tln,
                                          E_NONE, 1'b0));
                        restart = 1'b1;
                    end
                end
                default: restart = 1'b1;
            endcase

            if (restart) begin
                n_mode = M_IDLE;
                k = punct_kind(c);
                if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
                    // skip whitespace
                end else begin
                    n_ts  = r_cp;
                    n_tl  = LENGTH_BITS'(1);
                    n_tln = r_cl;
                    if (c == "\"") n_mode = M_STRING;
                    else if (c == "#") n_mode = M_COMMENT;
                    else if (is_alpha(c)) begin
                        n_mode = M_IDENT;
                        n_kc = narrow(7'h7F, '0, c);
                    end else if (is_digit(c)) n_mode = M_NUMBER;
                    else if (k != K_NONE) begin
                        push(res, cnt, mk(k, r_cp, LENGTH_BITS'(1), r_cl, E_NONE, 1'b0));
                    end else if (op_kind(c) != K_NONE || c == "&" || c == "|") begin
                        n_mode = M_PENDING;
                        n_ps = c;
                    end else begin
                        push(res, cnt, mk(K_ERROR, r_cp, LENGTH_BITS'(1), r_cl,
                                          E_UNKNOWN, 1'b1));
                        n_mode = M_STOPPED;
                    end
                end
            end

            n_cp = pos_inc(r_cp);
            if (c == 8'h0A) n_cl = pos_inc(r_cl);
        end
    end

    assign o_push    = accept && (cnt != 2'd0);
    assign o_rec.cnt = cnt;
    assign o_rec.res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_kc   <= 7'h7F;
            r_ps   <= '0;
            r_ts   <= '0;
            r_tl   <= '0;
            r_tln  <= POSITION_BITS'(1);
            r_cp   <= '0;
            r_cl   <= POSITION_BITS'(1);
        end else if (accept) begin
            r_mode <= n_mode;
            r_kc   <= n_kc;
            r_ps   <= n_ps;
            r_ts   <= n_ts;
            r_tl   <= n_tl;
            r_tln  <= n_tln;
            r_cp   <= n_cp;
            r_cl   <= n_cl;
        end
    end

endmodule

>>> rtl/core/stt_queue.sv
module stt_queue import stt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_rec o_rec
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_rec          mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rec   = mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wp] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

endmodule

>>> rtl/core/stt_back.sv
module stt_back import stt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_q_valid,
    input  t_rec     i_q_rec,
    output logic     o_pop,
    output logic     o_valid,
    input  logic     i_ready,
    output t_tok_out o_word
);

    logic [1:0] r_sub;
    logic       r_valid;
    t_tok_out   r_word;
    logic       load;
    logic       last_sub;

    assign load     = !r_valid || i_ready;
    assign last_sub = (r_sub == i_q_rec.cnt - 2'd1);
    assign o_pop    = load && i_q_valid && last_sub;
    assign o_valid  = r_valid;
    assign o_word   = r_word;

    // step through the tokens of the head record, one word per cycle while the output is not stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= '0;
        end else if (load) begin
            r_valid <= i_q_valid;
            if (i_q_valid) begin
                r_sub <= last_sub ? 2'd0 : r_sub + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_q_valid) begin
            r_word <= i_q_rec.res[r_sub];
        end
    end

endmodule

>>> rtl/core/source_text_tokenizer.sv
// Streaming tokenizer: one source character word per cycle in, one token word
// per cycle out while the output is ready. Identifiers, seven keywords, numbers,
// strings, #-comments and symbols come out with kind, start, length and line; an
// end_of_source word closes the stream with EOF (or an error word if a string or
// operator is open), and an error word stops the block until reset. A character
// can release up to three tokens; these sit in a four-record queue in front of
// the output register; input takes one word per cycle unless the queue is full.
module source_text_tokenizer import stt_pkg::*; #(
    parameter int POSITION_BITS = 16,
    parameter int LENGTH_BITS   = 8
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_tok_in  i_word,
    output logic     o_valid,
    input  logic     i_ready,
    output t_tok_out o_word
);

    logic q_full, q_push, q_pop, q_valid;
    t_rec push_rec, head_rec;

    stt_front #(
        .POSITION_BITS(POSITION_BITS),
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_word(i_word),
        .i_q_full(q_full), .o_push(q_push), .o_rec(push_rec)
    );

    stt_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(q_push), .i_rec(push_rec), .o_full(q_full),
        .i_pop(q_pop), .o_valid(q_valid), .o_rec(head_rec)
    );

    stt_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .i_q_rec(head_rec), .o_pop(q_pop),
        .o_valid(o_valid), .i_ready(i_ready), .o_word(o_word)
    );

endmodule
